// ===== design/rdc_pkg.sv =====
// rdc_pkg: widths, step counts and the command word shared by the
// radix_digit_converter controller, datapath and top level
// no dependencies
`timescale 1ns / 1ps

package rdc_pkg;

    // word and digit geometry
    localparam int WORD_W     = 60;
    localparam int BASE_W     = 4;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 18;
    localparam int BCD_DIGITS = 19;                    // 2^60 - 1 has 19 decimal digits
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int TDIG_W     = MAX_DIGITS * DIGIT_W;

    localparam int MIN_BASE   = 2;
    localparam int DEC_RADIX  = 10;

    // bits taken per double-dabble cycle
    localparam int DD_BITS    = 2;

    // steps in each phase
    localparam int BIN2BCD_STEPS = WORD_W / DD_BITS;
    localparam int DECODE_STEPS  = BCD_DIGITS;
    localparam int ENCODE_STEPS  = WORD_W;
    localparam int PACK_STEPS    = MAX_DIGITS;

    localparam int CNT_W = $clog2(WORD_W);

    // controller to datapath commands
    typedef struct packed {
        logic start;      // capture a new word
        logic bin2bcd;    // two double-dabble steps
        logic decode;     // horner step in the source base
        logic encode;     // shift one value bit into the target-base digits
        logic pack;       // horner step in base ten over target digits
        logic load_out;   // move the result into the output register
    } t_dp_cmd;

endpackage

// ===== design/rdc_ctrl.sv =====
// rdc_ctrl: sequencer for radix_digit_converter, runs the four phases
// and owns the output valid; depends on rdc_pkg
`timescale 1ns / 1ps

module rdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rdc_pkg::t_dp_cmd o_cmd
);
    import rdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIN2BCD,
        S_DECODE,
        S_ENCODE,
        S_PACK,
        S_FINISH
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic               out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_BIN2BCD;
                    n_count = CNT_W'(BIN2BCD_STEPS - 1);
                end
            end
            S_BIN2BCD: begin
                if (r_count == '0) begin
                    n_state = S_DECODE;
                    n_count = CNT_W'(DECODE_STEPS - 1);
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            S_DECODE: begin
                if (r_count == '0) begin
                    n_state = S_ENCODE;
                    n_count = CNT_W'(ENCODE_STEPS - 1);
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            S_ENCODE: begin
                if (r_count == '0) begin
                    n_state = S_PACK;
                    n_count = CNT_W'(PACK_STEPS - 1);
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            S_PACK: begin
                if (r_count == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.bin2bcd  = (r_state == S_BIN2BCD);
        o_cmd.decode   = (r_state == S_DECODE);
        o_cmd.encode   = (r_state == S_ENCODE);
        o_cmd.pack     = (r_state == S_PACK);
        o_cmd.load_out = (r_state == S_FINISH) && out_free;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.start, o_cmd.bin2bcd, o_cmd.decode,
                  o_cmd.encode, o_cmd.pack, o_cmd.load_out}))
        else $error("rdc_ctrl: more than one datapath command");

    a_start_loads_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=>
            (r_state == S_BIN2BCD && r_count == CNT_W'(BIN2BCD_STEPS - 1)))
        else $error("rdc_ctrl: accepted word did not start conversion");

    a_encode_to_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENCODE && r_count == '0) |=>
            (r_state == S_PACK && r_count == CNT_W'(PACK_STEPS - 1)))
        else $error("rdc_ctrl: encode phase did not end in pack");

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_cmd.load_out))
        else $error("rdc_ctrl: result shown without a load");
`endif

endmodule

// ===== design/rdc_datapath.sv =====
// rdc_datapath: double-dabble, shared multiply-add and base-b digit
// doubler for radix_digit_converter; depends on rdc_pkg
`timescale 1ns / 1ps

module rdc_datapath (
    input  logic                         i_clk,
    input  rdc_pkg::t_dp_cmd             i_cmd,
    input  logic [rdc_pkg::WORD_W-1:0]   i_digit_word,
    input  logic [rdc_pkg::BASE_W-1:0]   i_source_base,
    input  logic [rdc_pkg::BASE_W-1:0]   i_target_base,
    output logic [rdc_pkg::WORD_W-1:0]   o_converted_word,
    output logic                         o_overflow
);
    import rdc_pkg::*;

    localparam int DD_ADD = (1 << (DIGIT_W - 1)) - DEC_RADIX / 2;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] res;
        res = b;
        if (b < BASE_W'(MIN_BASE)) begin
            res = BASE_W'(MIN_BASE);
        end else if (b > BASE_W'(DEC_RADIX)) begin
            res = BASE_W'(DEC_RADIX);
        end
        return res;
    endfunction

    // one binary-to-bcd step: add-3 fixup on every digit, then shift a bit in
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic           bit_in);
        logic [BCD_W-1:0]   adj;
        logic [DIGIT_W-1:0] d;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            d = bcd[i*DIGIT_W +: DIGIT_W];
            adj[i*DIGIT_W +: DIGIT_W] = (d >= DIGIT_W'(DEC_RADIX / 2))
                                        ? d + DIGIT_W'(DD_ADD) : d;
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    logic [WORD_W-1:0]  r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [WORD_W-1:0]  r_acc;
    logic [TDIG_W-1:0]  r_tdig;
    logic [BASE_W-1:0]  r_sb;
    logic [BASE_W-1:0]  r_tb;
    logic               r_ovf;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_ovf;

    // shared multiply-add: acc * base + digit
    logic [BASE_W-1:0]          ma_mult;
    logic [DIGIT_W-1:0]         ma_digit;
    logic [WORD_W+BASE_W-1:0]   ma_prod;
    logic [WORD_W-1:0]          ma_next;

    always_comb begin
        ma_mult  = i_cmd.pack ? BASE_W'(DEC_RADIX) : r_sb;
        ma_digit = i_cmd.pack ? r_tdig[TDIG_W-1 -: DIGIT_W] : r_bcd[BCD_W-1 -: DIGIT_W];
        ma_prod  = {{BASE_W{1'b0}}, r_acc} * {{WORD_W{1'b0}}, ma_mult};
        ma_next  = ma_prod[WORD_W-1:0] + {{(WORD_W-DIGIT_W){1'b0}}, ma_digit};
    end

    // base-b doubling of the target digits with carry via one add
    logic [MAX_DIGITS-1:0]  dbl_gen, dbl_prop;
    logic [MAX_DIGITS:0]    dbl_sum, dbl_carry;
    logic [TDIG_W-1:0]      tdig_next;
    logic [DIGIT_W:0]       dbl_tmp;
    logic [DIGIT_W-1:0]     dbl_d;

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            dbl_d       = r_tdig[i*DIGIT_W +: DIGIT_W];
            dbl_gen[i]  = {dbl_d, 1'b0} >= {1'b0, r_tb};
            dbl_prop[i] = !dbl_gen[i] && ({dbl_d, 1'b1} >= {1'b0, r_tb});
        end
        dbl_sum   = {1'b0, dbl_gen | dbl_prop} + {1'b0, dbl_gen}
                  + {{MAX_DIGITS{1'b0}}, r_acc[WORD_W-1]};
        dbl_carry = dbl_sum ^ {1'b0, dbl_gen | dbl_prop} ^ {1'b0, dbl_gen};
        for (int i = 0; i < MAX_DIGITS; i++) begin
            dbl_d   = r_tdig[i*DIGIT_W +: DIGIT_W];
            dbl_tmp = {dbl_d, dbl_carry[i]}
                    - (dbl_carry[i+1] ? {1'b0, r_tb} : {(DIGIT_W+1){1'b0}});
            tdig_next[i*DIGIT_W +: DIGIT_W] = dbl_tmp[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_bin  <= i_digit_word;
            r_bcd  <= '0;
            r_acc  <= '0;
            r_tdig <= '0;
            r_sb   <= clamp_base(i_source_base);
            r_tb   <= clamp_base(i_target_base);
            r_ovf  <= 1'b0;
        end
        if (i_cmd.bin2bcd) begin
            r_bcd <= dd_step(dd_step(r_bcd, r_bin[WORD_W-1]), r_bin[WORD_W-2]);
            r_bin <= r_bin << DD_BITS;
        end
        if (i_cmd.decode) begin
            r_acc <= ma_next;
            r_bcd <= r_bcd << DIGIT_W;
        end
        if (i_cmd.encode) begin
            r_acc  <= r_acc << 1;
            r_tdig <= tdig_next;
            if (dbl_carry[MAX_DIGITS]) begin
                r_ovf <= 1'b1;
            end
        end
        if (i_cmd.pack) begin
            r_acc  <= ma_next;
            r_tdig <= r_tdig << DIGIT_W;
        end
        if (i_cmd.load_out) begin
            r_out_word <= r_ovf ? '0 : r_acc;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_converted_word = r_out_word;
    assign o_overflow       = r_out_ovf;

endmodule

// ===== design/radix_digit_converter.sv =====
// radix_digit_converter: reads each decimal digit of a word as a digit of
// the source base and rewrites the value with one target-base digit per
// decimal digit. an accepted word runs through the double-dabble, decode,
// encode and pack phases and then the output load, which waits for a free output register;
// the phases run in turn, and a new word is taken only once idle is reached again.
// synchronous active-low reset clears the sequencer and the output valid.
`timescale 1ns / 1ps

module radix_digit_converter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rdc_pkg::WORD_W-1:0]   i_digit_word,
    input  logic [rdc_pkg::BASE_W-1:0]   i_source_base,
    input  logic [rdc_pkg::BASE_W-1:0]   i_target_base,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rdc_pkg::WORD_W-1:0]   o_converted_word,
    output logic                         o_overflow
);
    import rdc_pkg::*;

    // commands from the sequencer to the datapath
    t_dp_cmd cmd;

    // sequencer: idle, binary-to-bcd, decode in the source base,
    // encode into target-base digits, pack those digits into binary,
    // then park the result in the output register
    rdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // datapath: the decimal digits come from a double-dabble pass over
    // the input word, the value from a horner loop on the shared
    // multiply-add, the target digits from shifting value bits msb first
    // into a base-b digit vector (doubling with a single carry add), and
    // the output word from a second horner loop in base ten
    // overflow is a sticky carry out of the top target digit
    rdc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_digit_word     (i_digit_word),
        .i_source_base    (i_source_base),
        .i_target_base    (i_target_base),
        .o_converted_word (o_converted_word),
        .o_overflow       (o_overflow)
    );

endmodule
